@@ design/assert_macros.svh @@
// Assertion helpers used by circle_box_contact_detect.
// Clocked, reset-disabled concurrent assertion wrappers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ design/cbcd_pkg.sv @@
// Types and constants for the circle versus oriented box contact detector.
// No dependencies; used by circle_box_contact_detect.
`timescale 1ns / 1ps

package cbcd_pkg;

	// Fixed-point formats
	localparam int COORD_W   = 32;
	localparam int SIZE_W    = 31;
	localparam int ANGLE_W   = 16;
	localparam int FRAC_BITS = 16;
	localparam int NORM_FRAC = 14;
	localparam int ADDR_W    = 5;
	localparam int ROOT_W    = 32;
	localparam int QUOT_W    = 15;

	localparam logic signed [ANGLE_W-1:0] NORM_ONE     = 16'sd16384;
	localparam logic signed [ANGLE_W-1:0] NORM_NEG_ONE = -16'sd16384;
	localparam logic [SIZE_W-1:0]         SIZE_ONE     = 31'(1) << FRAC_BITS;

	// Register map (word index)
	typedef enum logic [2:0] {
		REG_CENTRE_X    = 3'd0,
		REG_CENTRE_Y    = 3'd1,
		REG_HALF_WIDTH  = 3'd2,
		REG_HALF_HEIGHT = 3'd3,
		REG_COS_ANGLE   = 3'd4,
		REG_SIN_ANGLE   = 3'd5
	} reg_idx_t;

	// Face picked by the smallest penetration
	typedef enum logic [1:0] {
		FACE_NEG_X = 2'd0,
		FACE_POS_X = 2'd1,
		FACE_NEG_Y = 2'd2,
		FACE_POS_Y = 2'd3
	} face_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [SIZE_W-1:0]         radius;
	} in_item_t;

	typedef struct packed {
		logic                      hit;
		logic [SIZE_W-1:0]         overlap;
		logic signed [ANGLE_W-1:0] normal_x;
		logic signed [ANGLE_W-1:0] normal_y;
		logic signed [COORD_W-1:0] local_x;
		logic signed [COORD_W-1:0] local_y;
	} result_t;

	// Per-item context carried through the root and divide stages
	typedef struct packed {
		logic signed [COORD_W-1:0] local_x;
		logic signed [COORD_W-1:0] local_y;
		logic                      miss;
		logic                      corner;
		logic                      corner_hit;
		face_t                     face;
		logic [SIZE_W-1:0]         face_ov;
		logic [SIZE_W-1:0]         radius;
		logic                      dx_neg;
		logic                      dy_neg;
		logic [SIZE_W-1:0]         adx;
		logic [SIZE_W-1:0]         ady;
	} ctx_t;

endpackage

@@ design/circle_box_contact_detect.sv @@
// Circle versus oriented box contact detector, fully pipelined.
// Depends on cbcd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One item enters per clock and its result leaves on a one-cycle done strobe
// after the last stage; the receiver cannot hold results off, so busy stays
// low and items may be issued every cycle. The pipeline holds the rotation
// and contact stages (6), a 32-stage bit-per-stage square root and a 15-stage
// normal divider (one quotient bit per stage, both axes in parallel), plus
// the output register. The user must write box registers over the APB port
// only while no item is in flight (not enforced by the block); otherwise they hold.
module circle_box_contact_detect (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  cbcd_pkg::in_item_t            item,
	output logic                          done,
	output cbcd_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cbcd_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int SQ_STAGES = cbcd_pkg::ROOT_W;
	localparam int DV_STAGES = cbcd_pkg::QUOT_W;

	// Box registers
	logic signed [31:0] cx_q, cy_q;
	logic [30:0]        hw_q, hh_q;
	logic signed [15:0] cos_q, sin_q;
	logic               wr_en;
	cbcd_pkg::reg_idx_t wr_idx;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite;
	assign wr_idx = cbcd_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			hw_q  <= cbcd_pkg::SIZE_ONE;
			hh_q  <= cbcd_pkg::SIZE_ONE;
			cos_q <= cbcd_pkg::NORM_ONE;
			sin_q <= '0;
		end else if (wr_en) begin
			unique case (wr_idx)
				cbcd_pkg::REG_CENTRE_X:    cx_q  <= pwdata;
				cbcd_pkg::REG_CENTRE_Y:    cy_q  <= pwdata;
				cbcd_pkg::REG_HALF_WIDTH:  hw_q  <= pwdata[30:0];
				cbcd_pkg::REG_HALF_HEIGHT: hh_q  <= pwdata[30:0];
				cbcd_pkg::REG_COS_ANGLE:   cos_q <= pwdata[15:0];
				cbcd_pkg::REG_SIN_ANGLE:   sin_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		unique case (wr_idx)
			cbcd_pkg::REG_CENTRE_X:    prdata = cx_q;
			cbcd_pkg::REG_CENTRE_Y:    prdata = cy_q;
			cbcd_pkg::REG_HALF_WIDTH:  prdata = {1'b0, hw_q};
			cbcd_pkg::REG_HALF_HEIGHT: prdata = {1'b0, hh_q};
			cbcd_pkg::REG_COS_ANGLE:   prdata = {{16{cos_q[15]}}, cos_q};
			cbcd_pkg::REG_SIN_ANGLE:   prdata = {{16{sin_q[15]}}, sin_q};
			default:                   prdata = '0;
		endcase
	end

	// Saturate a 36-bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > $signed(36'h07FFFFFFF))
			r = 32'sh7FFFFFFF;
		else if (v < $signed(36'hF80000000))
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Stage 1: offset from box centre
	logic               vld_s1;
	logic signed [32:0] gx_s1, gy_s1;
	logic [30:0]        r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		gx_s1 <= $signed({item.point_x[31], item.point_x}) - $signed({cx_q[31], cx_q});
		gy_s1 <= $signed({item.point_y[31], item.point_y}) - $signed({cy_q[31], cy_q});
		r_s1  <= item.radius;
	end

	// Stage 2: rotation products
	logic               vld_s2;
	logic signed [48:0] gxc_s2, gys_s2, gyc_s2, gxs_s2;
	logic [30:0]        r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		gxc_s2 <= gx_s1 * cos_q;
		gys_s2 <= gy_s1 * sin_q;
		gyc_s2 <= gy_s1 * cos_q;
		gxs_s2 <= gx_s1 * sin_q;
		r_s2   <= r_s1;
	end

	// Stage 3: sum, floor shift, saturate; grown half sizes
	logic signed [49:0] sum_x, sum_y;
	logic               vld_s3;
	logic signed [31:0] lx_s3, ly_s3;
	logic [31:0]        bx_s3, by_s3;
	logic [30:0]        r_s3;

	assign sum_x = $signed({gxc_s2[48], gxc_s2}) + $signed({gys_s2[48], gys_s2});
	assign sum_y = $signed({gyc_s2[48], gyc_s2}) - $signed({gxs_s2[48], gxs_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		lx_s3 <= sat32($signed(sum_x[49:14]));
		ly_s3 <= sat32($signed(sum_y[49:14]));
		bx_s3 <= {1'b0, hw_q} + {1'b0, r_s2};
		by_s3 <= {1'b0, hh_q} + {1'b0, r_s2};
		r_s3  <= r_s2;
	end

	// Stage 4: region tests, corner offsets, face penetrations
	logic signed [33:0] lxe, lye, bxe, bye, hxe, hye, dx, dy, adx_w, ady_w;
	logic               miss_w, cornx, corny;
	logic               vld_s4;
	logic signed [31:0] lx_s4, ly_s4;
	logic               miss_s4, corner_s4, dxn_s4, dyn_s4;
	logic [30:0]        adx_s4, ady_s4, r_s4;
	logic signed [33:0] pen_s4 [4];

	always_comb begin
		lxe    = {{2{lx_s3[31]}}, lx_s3};
		lye    = {{2{ly_s3[31]}}, ly_s3};
		bxe    = {2'b00, bx_s3};
		bye    = {2'b00, by_s3};
		hxe    = {3'b000, hw_q};
		hye    = {3'b000, hh_q};
		miss_w = (lxe < -bxe) || (lxe > bxe) || (lye < -bye) || (lye > bye);
		cornx  = (lxe < -hxe) || (lxe > hxe);
		corny  = (lye < -hye) || (lye > hye);
		dx     = lx_s3[31] ? lxe + hxe : lxe - hxe;
		dy     = ly_s3[31] ? lye + hye : lye - hye;
		adx_w  = dx[33] ? -dx : dx;
		ady_w  = dy[33] ? -dy : dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		lx_s4     <= lx_s3;
		ly_s4     <= ly_s3;
		miss_s4   <= miss_w;
		corner_s4 <= cornx && corny;
		dxn_s4    <= dx[33];
		dyn_s4    <= dy[33];
		adx_s4    <= adx_w[30:0];
		ady_s4    <= ady_w[30:0];
		r_s4      <= r_s3;
		pen_s4[0] <= lxe + bxe;
		pen_s4[1] <= bxe - lxe;
		pen_s4[2] <= lye + bye;
		pen_s4[3] <= bye - lye;
	end

	// Stage 5: squares and smallest face penetration (ties keep the earlier face)
	logic signed [33:0] best01, best23, best;
	cbcd_pkg::face_t    id01, id23, id_w;
	logic [30:0]        face_ov_w;
	logic               vld_s5;
	logic signed [31:0] lx_s5, ly_s5;
	logic               miss_s5, corner_s5, dxn_s5, dyn_s5;
	logic [30:0]        adx_s5, ady_s5, r_s5, face_ov_s5;
	cbcd_pkg::face_t    face_s5;
	logic [61:0]        sqx_s5, sqy_s5, rr_s5;

	always_comb begin
		if (pen_s4[0] > pen_s4[1]) begin
			best01 = pen_s4[1];
			id01   = cbcd_pkg::FACE_POS_X;
		end else begin
			best01 = pen_s4[0];
			id01   = cbcd_pkg::FACE_NEG_X;
		end
		if (pen_s4[2] > pen_s4[3]) begin
			best23 = pen_s4[3];
			id23   = cbcd_pkg::FACE_POS_Y;
		end else begin
			best23 = pen_s4[2];
			id23   = cbcd_pkg::FACE_NEG_Y;
		end
		if (best01 > best23) begin
			best = best23;
			id_w = id23;
		end else begin
			best = best01;
			id_w = id01;
		end
		if (best[33])
			face_ov_w = '0;
		else if (best > $signed(34'h07FFFFFFF))
			face_ov_w = '1;
		else
			face_ov_w = best[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		lx_s5      <= lx_s4;
		ly_s5      <= ly_s4;
		miss_s5    <= miss_s4;
		corner_s5  <= corner_s4;
		dxn_s5     <= dxn_s4;
		dyn_s5     <= dyn_s4;
		adx_s5     <= adx_s4;
		ady_s5     <= ady_s4;
		r_s5       <= r_s4;
		face_s5    <= id_w;
		face_ov_s5 <= face_ov_w;
		sqx_s5     <= adx_s4 * adx_s4;
		sqy_s5     <= ady_s4 * ady_s4;
		rr_s5      <= r_s4 * r_s4;
	end

	// Stage 6: squared distance and corner hit test; feeds the root pipeline
	logic [62:0]         sq_w;
	logic                sq_vld  [SQ_STAGES+1];
	cbcd_pkg::ctx_t      sq_ctx  [SQ_STAGES+1];
	logic [34:0]         sq_rem  [SQ_STAGES+1];
	logic [31:0]         sq_root [SQ_STAGES+1];
	logic [63:0]         sq_n    [SQ_STAGES+1];

	assign sq_w = {1'b0, sqx_s5} + {1'b0, sqy_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_vld[0] <= 1'b0;
		else
			sq_vld[0] <= vld_s5;
	end

	always_ff @(posedge clk) begin
		sq_ctx[0].local_x    <= lx_s5;
		sq_ctx[0].local_y    <= ly_s5;
		sq_ctx[0].miss       <= miss_s5;
		sq_ctx[0].corner     <= corner_s5;
		sq_ctx[0].corner_hit <= sq_w <= {1'b0, rr_s5};
		sq_ctx[0].face       <= face_s5;
		sq_ctx[0].face_ov    <= face_ov_s5;
		sq_ctx[0].radius     <= r_s5;
		sq_ctx[0].dx_neg     <= dxn_s5;
		sq_ctx[0].dy_neg     <= dyn_s5;
		sq_ctx[0].adx        <= adx_s5;
		sq_ctx[0].ady        <= ady_s5;
		sq_rem[0]            <= '0;
		sq_root[0]           <= '0;
		sq_n[0]              <= {1'b0, sq_w};
	end

	// Square root: one root bit per stage
	for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sqrt
		logic [34:0] rem_w, trial;
		logic        ge;

		always_comb begin
			rem_w = {sq_rem[i][32:0], sq_n[i][63:62]};
			trial = {1'b0, sq_root[i], 2'b01};
			ge    = rem_w >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_vld[i+1] <= 1'b0;
			else
				sq_vld[i+1] <= sq_vld[i];
		end

		always_ff @(posedge clk) begin
			sq_ctx[i+1]  <= sq_ctx[i];
			sq_rem[i+1]  <= ge ? rem_w - trial : rem_w;
			sq_root[i+1] <= {sq_root[i][30:0], ge};
			sq_n[i+1]    <= {sq_n[i][61:0], 2'b00};
		end
	end

	// Normal divider: |d| * 2^14 / root, one quotient bit per stage per axis
	logic                dv_vld [DV_STAGES+1];
	cbcd_pkg::ctx_t      dv_ctx [DV_STAGES+1];
	logic [31:0]         dv_d   [DV_STAGES+1];
	logic [31:0]         dv_rx  [DV_STAGES+1];
	logic [31:0]         dv_ry  [DV_STAGES+1];
	logic [14:0]         dv_qx  [DV_STAGES+1];
	logic [14:0]         dv_qy  [DV_STAGES+1];

	assign dv_vld[0] = sq_vld[SQ_STAGES];
	assign dv_ctx[0] = sq_ctx[SQ_STAGES];
	assign dv_d[0]   = sq_root[SQ_STAGES];
	assign dv_rx[0]  = {2'b00, sq_ctx[SQ_STAGES].adx[30:1]};
	assign dv_ry[0]  = {2'b00, sq_ctx[SQ_STAGES].ady[30:1]};
	assign dv_qx[0]  = '0;
	assign dv_qy[0]  = '0;

	for (genvar k = 0; k < DV_STAGES; k++) begin : g_div
		logic        bx_in, by_in, gex, gey;
		logic [32:0] tx, ty, dd;

		always_comb begin
			bx_in = (k == 0) ? dv_ctx[k].adx[0] : 1'b0;
			by_in = (k == 0) ? dv_ctx[k].ady[0] : 1'b0;
			tx    = {dv_rx[k], bx_in};
			ty    = {dv_ry[k], by_in};
			dd    = {1'b0, dv_d[k]};
			gex   = tx >= dd;
			gey   = ty >= dd;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld[k+1] <= 1'b0;
			else
				dv_vld[k+1] <= dv_vld[k];
		end

		always_ff @(posedge clk) begin
			dv_ctx[k+1] <= dv_ctx[k];
			dv_d[k+1]   <= dv_d[k];
			dv_rx[k+1]  <= gex ? 32'(tx - dd) : tx[31:0];
			dv_ry[k+1]  <= gey ? 32'(ty - dd) : ty[31:0];
			dv_qx[k+1]  <= {dv_qx[k][13:0], gex};
			dv_qy[k+1]  <= {dv_qy[k][13:0], gey};
		end
	end

	// Output register: pick corner, face or miss result
	cbcd_pkg::ctx_t     oc;
	logic signed [15:0] mag_x, mag_y;
	cbcd_pkg::result_t  res_w;

	assign oc    = dv_ctx[DV_STAGES];
	assign mag_x = {1'b0, dv_qx[DV_STAGES]};
	assign mag_y = {1'b0, dv_qy[DV_STAGES]};

	always_comb begin
		res_w.local_x  = oc.local_x;
		res_w.local_y  = oc.local_y;
		res_w.hit      = 1'b0;
		res_w.overlap  = '0;
		res_w.normal_x = '0;
		res_w.normal_y = '0;
		if (!oc.miss) begin
			if (oc.corner) begin
				if (oc.corner_hit) begin
					res_w.hit      = 1'b1;
					res_w.overlap  = oc.radius - dv_d[DV_STAGES][30:0];
					res_w.normal_x = oc.dx_neg ? -mag_x : mag_x;
					res_w.normal_y = oc.dy_neg ? -mag_y : mag_y;
				end
			end else begin
				res_w.hit     = 1'b1;
				res_w.overlap = oc.face_ov;
				case (oc.face)
					cbcd_pkg::FACE_NEG_X: res_w.normal_x = cbcd_pkg::NORM_NEG_ONE;
					cbcd_pkg::FACE_POS_X: res_w.normal_x = cbcd_pkg::NORM_ONE;
					cbcd_pkg::FACE_NEG_Y: res_w.normal_y = cbcd_pkg::NORM_NEG_ONE;
					default:              res_w.normal_y = cbcd_pkg::NORM_ONE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= dv_vld[DV_STAGES];
	end

	always_ff @(posedge clk) begin
		result <= res_w;
	end

	// Checks
	`ASSERT_PROP(a_latency, clk, arst_n, start && !busy |-> ##54 done, "item result missing after 54 cycles")
	`ASSERT_NEVER(a_miss_zero, clk, arst_n, done && !result.hit && (result.overlap != 0 || result.normal_x != 0 || result.normal_y != 0), "miss with nonzero depth or normal")
	`ASSERT_NEVER(a_hit_normal, clk, arst_n, done && result.hit && result.normal_x == 0 && result.normal_y == 0, "hit with zero normal")

endmodule

@@ test/circle_box_contact_detect_test.sv @@
// Self-checking testbench for circle_box_contact_detect: directed and random particles
// against several box settings, each result checked against an in-bench contact model.
// Depends on cbcd_pkg and the circle_box_contact_detect RTL.
`timescale 1ns / 1ps

module circle_box_contact_detect_test;

	localparam int  IDLE_LIMIT   = 1000;
	localparam int  DRAIN_CYCLES = 60;
	localparam int  PHASES       = 9;
	localparam int  PHASE_ITEMS  = 220;
	localparam longint COORD_HI  = 64'sd2147483647;
	localparam longint COORD_LO  = -64'sd2147483648;
	localparam longint ONE       = 64'sd65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cbcd_pkg::in_item_t item = '0;
	logic done;
	cbcd_pkg::result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [cbcd_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Box registers as the block should hold them
	logic signed [cbcd_pkg::COORD_W-1:0] box_cx = '0;
	logic signed [cbcd_pkg::COORD_W-1:0] box_cy = '0;
	logic [cbcd_pkg::SIZE_W-1:0] box_hw = cbcd_pkg::SIZE_ONE;
	logic [cbcd_pkg::SIZE_W-1:0] box_hh = cbcd_pkg::SIZE_ONE;
	logic signed [cbcd_pkg::ANGLE_W-1:0] box_cos = cbcd_pkg::NORM_ONE;
	logic signed [cbcd_pkg::ANGLE_W-1:0] box_sin = '0;

	cbcd_pkg::in_item_t particles_pending[$];
	cbcd_pkg::result_t contacts_expected[$];
	int send_idle_pct = 0;
	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_hits = 0;
	int n_corner = 0;
	int quiet_cycles = 0;

	circle_box_contact_detect dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Integer square root, floor
	function automatic longint unsigned root_of(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint sat_coord(longint v);
		return v < COORD_LO ? COORD_LO : (v > COORD_HI ? COORD_HI : v);
	endfunction

	// Contact of one particle with the current box
	function automatic cbcd_pkg::result_t contact_of(cbcd_pkg::in_item_t it);
		cbcd_pkg::result_t res;
		longint gx, gy, lx, ly, r, hx, hy, bx, by, dx, dy, d, best, t, nx, ny;
		longint unsigned sq, rr, adx, ady;
		cbcd_pkg::face_t face;
		res = '0;
		r = longint'(it.radius);
		hx = longint'(box_hw);
		hy = longint'(box_hh);
		gx = longint'(it.point_x) - longint'(box_cx);
		gy = longint'(it.point_y) - longint'(box_cy);
		lx = sat_coord((gx * longint'(box_cos) + gy * longint'(box_sin)) >>>
			cbcd_pkg::NORM_FRAC);
		ly = sat_coord((gy * longint'(box_cos) - gx * longint'(box_sin)) >>>
			cbcd_pkg::NORM_FRAC);
		bx = hx + r;
		by = hy + r;
		res.local_x = lx[31:0];
		res.local_y = ly[31:0];
		if (lx < -bx || lx > bx || ly < -by || ly > by) return res;
		if ((lx < -hx || lx > hx) && (ly < -hy || ly > hy)) begin
			// corner region: contact with the nearest corner
			dx = lx < 0 ? lx + hx : lx - hx;
			dy = ly < 0 ? ly + hy : ly - hy;
			adx = dx < 0 ? -dx : dx;
			ady = dy < 0 ? -dy : dy;
			sq = adx * adx + ady * ady;
			rr = r * r;
			if (sq <= rr) begin
				d = root_of(sq);
				nx = (dx * longint'(cbcd_pkg::NORM_ONE)) / d;
				ny = (dy * longint'(cbcd_pkg::NORM_ONE)) / d;
				res.hit = 1'b1;
				res.overlap = cbcd_pkg::SIZE_W'(r - d);
				res.normal_x = nx[15:0];
				res.normal_y = ny[15:0];
			end
		end else begin
			// face region: first smallest penetration wins
			best = lx + bx;
			face = cbcd_pkg::FACE_NEG_X;
			t = bx - lx;
			if (best > t) begin best = t; face = cbcd_pkg::FACE_POS_X; end
			t = ly + by;
			if (best > t) begin best = t; face = cbcd_pkg::FACE_NEG_Y; end
			t = by - ly;
			if (best > t) begin best = t; face = cbcd_pkg::FACE_POS_Y; end
			if (best < 0) best = 0;
			if (best > COORD_HI) best = COORD_HI;
			res.hit = 1'b1;
			res.overlap = cbcd_pkg::SIZE_W'(best);
			res.normal_x = face == cbcd_pkg::FACE_NEG_X ? cbcd_pkg::NORM_NEG_ONE :
				(face == cbcd_pkg::FACE_POS_X ? cbcd_pkg::NORM_ONE : '0);
			res.normal_y = face == cbcd_pkg::FACE_NEG_Y ? cbcd_pkg::NORM_NEG_ONE :
				(face == cbcd_pkg::FACE_POS_Y ? cbcd_pkg::NORM_ONE : '0);
		end
		return res;
	endfunction

	// Driver: issue pending items, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				contacts_expected.push_back(contact_of(item));
				n_items++;
			end
			if (!start || !busy) begin
				if (particles_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					start <= 1'b1;
					item <= particles_pending.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		cbcd_pkg::result_t want;
		if (arst_n && done) begin
			n_results++;
			if (contacts_expected.size() == 0) begin
				$display("%0t: unexpected result, got %h", $time, result);
				errors++;
			end else begin
				want = contacts_expected.pop_front();
				if (want.hit) n_hits++;
				if (want.hit && want.normal_x != 0 && want.normal_y != 0) n_corner++;
				check_field("hit", want.hit, result.hit);
				check_field("overlap", want.overlap, result.overlap);
				check_field("normal_x", want.normal_x, result.normal_x);
				check_field("normal_y", want.normal_y, result.normal_y);
				check_field("local_x", want.local_x, result.local_x);
				check_field("local_y", want.local_y, result.local_y);
			end
		end
	end

	// Watchdog on cycles with no progress
	always @(posedge clk) begin
		if ((start && !busy) || done || psel) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// APB register write; the model copy follows at the access edge
	task automatic write_reg(cbcd_pkg::reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= cbcd_pkg::ADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			cbcd_pkg::REG_CENTRE_X:    box_cx = value;
			cbcd_pkg::REG_CENTRE_Y:    box_cy = value;
			cbcd_pkg::REG_HALF_WIDTH:  box_hw = value[cbcd_pkg::SIZE_W-1:0];
			cbcd_pkg::REG_HALF_HEIGHT: box_hh = value[cbcd_pkg::SIZE_W-1:0];
			cbcd_pkg::REG_COS_ANGLE:   box_cos = value[cbcd_pkg::ANGLE_W-1:0];
			cbcd_pkg::REG_SIN_ANGLE:   box_sin = value[cbcd_pkg::ANGLE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_box(longint cx, longint cy, longint hw, longint hh, int c, int s);
		write_reg(cbcd_pkg::REG_CENTRE_X, cx[31:0]);
		write_reg(cbcd_pkg::REG_CENTRE_Y, cy[31:0]);
		write_reg(cbcd_pkg::REG_HALF_WIDTH, {1'b0, hw[30:0]});
		write_reg(cbcd_pkg::REG_HALF_HEIGHT, {1'b0, hh[30:0]});
		write_reg(cbcd_pkg::REG_COS_ANGLE, 32'(c));
		write_reg(cbcd_pkg::REG_SIN_ANGLE, 32'(s));
	endtask

	task automatic add_particle(longint x, longint y, longint r);
		cbcd_pkg::in_item_t p;
		p.point_x = x[31:0];
		p.point_y = y[31:0];
		p.radius = r[30:0];
		particles_pending.push_back(p);
	endtask

	// Hold off new items until every result is back
	task automatic drain();
		wait (particles_pending.size() == 0 && !start && contacts_expected.size() == 0);
		@(posedge clk);
	endtask

	function automatic longint rand_coord();
		return longint'(signed'($urandom()));
	endfunction

	// Random particle: mostly near the box, some anywhere
	task automatic add_random_particle();
		longint r, span, ox, oy;
		if ($urandom_range(9) < 2) begin
			add_particle(rand_coord(), rand_coord(), longint'($urandom() >> 1));
		end else begin
			r = $urandom_range(3) == 0 ? 0 : longint'($urandom_range(0, 3 * 65536));
			span = longint'(box_hw) + longint'(box_hh) + 2 * r + ONE;
			if (span > 64'sd1073741824) span = 64'sd1073741824;
			ox = longint'($urandom_range(0, 32'(2 * span))) - span;
			oy = longint'($urandom_range(0, 32'(2 * span))) - span;
			add_particle(longint'(box_cx) + ox, longint'(box_cy) + oy, r);
		end
	endtask

	// Random box setting; a few fixed ones cover the register extremes
	task automatic pick_box(int phase);
		real a;
		int c, s;
		a = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
		c = $rtoi($cos(a) * 16384.0);
		s = $rtoi($sin(a) * 16384.0);
		case (phase)
			1: write_box(COORD_HI, COORD_LO, 0, 0, -16384, 0);
			2: write_box(COORD_LO, COORD_HI, COORD_HI, COORD_HI, 0, 16384);
			3: write_box(0, 0, 3 * ONE, ONE / 2, 0, -16384);
			4: write_box(rand_coord(), rand_coord(), $urandom_range(0, 4 * 65536),
				$urandom_range(0, 4 * 65536), -32768, 32767);
			default: write_box(rand_coord() >>> 4, rand_coord() >>> 4,
				$urandom_range(0, 4 * 65536), $urandom_range(0, 4 * 65536), c, s);
		endcase
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items against the reset box: square of half size one at the origin
		send_idle_pct = 13;
		add_particle(0, 0, 0);
		add_particle(2 * ONE, 0, ONE);              // exactly on the grown edge
		add_particle(-2 * ONE, 0, ONE);
		add_particle(0, 2 * ONE, ONE);
		add_particle(0, -2 * ONE - 1, ONE);         // just outside
		add_particle(ONE / 2, ONE / 4, ONE / 8);    // face picked from inside
		add_particle(-ONE / 2, ONE / 4, 0);
		add_particle(ONE / 4, -ONE / 2, 0);
		add_particle(4 * ONE, 5 * ONE, 5 * ONE);    // corner exactly on the circle
		add_particle(-3 * ONE / 2, -3 * ONE / 2, ONE);
		add_particle(3 * ONE / 2, -3 * ONE / 2, ONE / 2);
		add_particle(3 * ONE / 2, 3 * ONE / 2, ONE / 2); // corner miss
		add_particle(3 * ONE, 3 * ONE, 0);
		add_particle(COORD_HI, COORD_HI, COORD_HI);
		add_particle(COORD_LO, COORD_LO, COORD_HI);
		add_particle(COORD_HI, COORD_LO, 0);
		add_particle(COORD_LO, COORD_HI, COORD_HI);
		add_particle(-1, -1, 1);
		drain();
		write_box(0, 0, ONE, ONE, 11585, 11585);    // rotated by 45 degrees
		add_particle(ONE, ONE, ONE);
		add_particle(2 * ONE, 0, ONE);
		add_particle(COORD_HI, COORD_LO, COORD_HI);
		drain();

		// Random phases, a fresh box each
		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct = p < 3 ? 13 : (p < 6 ? 63 : 0);
			pick_box(p);
			for (int i = 0; i < PHASE_ITEMS; i++) add_random_particle();
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d particles, %0d results, %0d hits (%0d at corners)",
			n_items, n_results, n_hits, n_corner);
		$display("Box settings covered reset, extremes, rotations and out-of-range angles");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
